FILE: hw/rtl/dlle_pkg.sv
// Shared types and codes for the doubly linked list engine.
`timescale 1ns / 1ps
package dlle_pkg;
   localparam int Capacity  = 256;
   localparam int IdxWidth  = 9;
   localparam int AddrWidth = 8;
   localparam int DataWidth = 32;
   localparam logic [IdxWidth-1:0] NullIdx = 9'd256;

   typedef enum logic [3:0] {
      OP_INS_FIRST = 4'd0, OP_INS_LAST = 4'd1, OP_CUR_FIRST = 4'd2,
      OP_CUR_LAST = 4'd3, OP_DEL_FIRST = 4'd4, OP_DEL_LAST = 4'd5,
      OP_DEL_AFTER = 4'd6, OP_DEL_BEFORE = 4'd7, OP_INS_AFTER = 4'd8,
      OP_INS_BEFORE = 4'd9, OP_WRITE = 4'd10, OP_NEXT = 4'd11,
      OP_PREV = 4'd12, OP_CLEAR = 4'd13, OP_QUERY = 4'd14, OP_SPARE = 4'd15
   } op_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               error;
      logic               list_empty;
      logic               cursor_active;
      logic signed [31:0] first_value;
      logic signed [31:0] last_value;
      logic signed [31:0] cursor_value;
      logic [8:0]         element_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD1, ST_RD2, ST_WR, ST_OUT1, ST_OUT2, ST_OUT3, ST_DONE
   } state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic take;     // latch request
      logic rd1;      // issue first read (cursor / end links)
      logic rd2;      // issue second read (neighbor / free link)
      logic wr;       // compute and apply the update
      logic out1;     // read first value
      logic out2;     // read last value, capture first
      logic out3;     // read cursor value, capture last
      logic done;     // build result
   } cmd_type;
endpackage

FILE: hw/rtl/dlle_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dlle_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: hw/rtl/dlle_ctrl.sv
// Sequencing state machine of the list engine.
`timescale 1ns / 1ps
module dlle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dlle_pkg::cmd_type cmd
);
   import dlle_pkg::*;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin cmd.rd1 = 1'b1; state_in = ST_RD2; end
         ST_RD2: begin cmd.rd2 = 1'b1; state_in = ST_WR; end
         ST_WR:  begin cmd.wr = 1'b1; state_in = ST_OUT1; end
         ST_OUT1: begin cmd.out1 = 1'b1; state_in = ST_OUT2; end
         ST_OUT2: begin cmd.out2 = 1'b1; state_in = ST_OUT3; end
         ST_OUT3: begin cmd.out3 = 1'b1; state_in = ST_DONE; end
         ST_DONE: begin
            // hold until the previous item has left the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.done     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: hw/rtl/dlle_dpath.sv
// List datapath: index registers, node memories and update logic.
`timescale 1ns / 1ps
module dlle_dpath (
   input  logic              clock,
   input  logic              reset,
   input  dlle_pkg::cmd_type cmd,
   input  dlle_pkg::req_type req_data,
   output dlle_pkg::rsp_type rsp_data
);
   import dlle_pkg::*;

   // Each link memory has a private port; up to two link words are written
   // per item in the update step, so each memory takes its second write
   // through a deferred slot that is flushed in the out1 step.
   logic [IdxWidth-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [IdxWidth-1:0] free_ff, free_in, fresh_ff, fresh_in, count_ff, count_in;
   logic [3:0]          mode_ff;
   logic [DataWidth-1:0] val_ff;
   logic                err_ff, err_in;
   rsp_type             rsp_ff;

   // Memory ports.
   logic                 nx_we, pv_we, dt_we;
   logic [AddrWidth-1:0] nx_a, pv_a, dt_a;
   logic [IdxWidth-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;
   logic [DataWidth-1:0] dt_wd, dt_rd;

   // Values fetched in the read steps.
   logic [IdxWidth-1:0] c_next_ff, c_prev_ff, e_link, f_link;
   // Deferred second link writes.
   logic                nx2_v_ff, nx2_v_in, pv2_v_ff, pv2_v_in;
   logic [AddrWidth-1:0] nx2_a_ff, nx2_a_in, pv2_a_ff, pv2_a_in;
   logic [IdxWidth-1:0]  nx2_d_ff, nx2_d_in, pv2_d_ff, pv2_d_in;
   logic [DataWidth-1:0] first_ff, last_ff;

   dlle_ram #(.Width(IdxWidth), .Depth(Capacity)) u_next (
      .clock, .wr_en(nx_we), .addr(nx_a), .wr_data(nx_wd), .rd_data(nx_rd));
   dlle_ram #(.Width(IdxWidth), .Depth(Capacity)) u_prev (
      .clock, .wr_en(pv_we), .addr(pv_a), .wr_data(pv_wd), .rd_data(pv_rd));
   dlle_ram #(.Width(DataWidth), .Depth(Capacity)) u_data (
      .clock, .wr_en(dt_we), .addr(dt_a), .wr_data(dt_wd), .rd_data(dt_rd));

   function automatic logic [AddrWidth-1:0] ad(input logic [IdxWidth-1:0] i);
      return i[AddrWidth-1:0];
   endfunction

   op_type op;
   assign op = op_type'(mode_ff);
   logic c_ok;
   assign c_ok = (cur_ff != NullIdx);

   // Allocation result.
   logic [IdxWidth-1:0] alloc;
   logic                alloc_ok;
   always_comb begin
      if (free_ff != NullIdx) begin
         alloc = free_ff; alloc_ok = 1'b1;
      end else if (fresh_ff != NullIdx) begin
         alloc = fresh_ff; alloc_ok = 1'b1;
      end else begin
         alloc = NullIdx; alloc_ok = 1'b0;
      end
   end

   // Read step addresses: rd1 reads next/prev of cursor (or end node);
   // rd2 reads the victim's far link or next of the free head.
   logic [IdxWidth-1:0] rd1_node;
   always_comb begin
      unique case (op)
         OP_DEL_FIRST: rd1_node = head_ff;
         OP_DEL_LAST:  rd1_node = tail_ff;
         default:      rd1_node = cur_ff;
      endcase
   end

   // Update step.
   logic [IdxWidth-1:0] del_nb;
   always_comb begin
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      free_in = free_ff; fresh_in = fresh_ff; count_in = count_ff;
      err_in = 1'b0;
      nx_we = 1'b0; pv_we = 1'b0; dt_we = 1'b0;
      nx_a = ad(rd1_node); pv_a = ad(rd1_node); dt_a = ad(cur_ff);
      nx_wd = '0; pv_wd = '0; dt_wd = val_ff;
      nx2_v_in = 1'b0; pv2_v_in = 1'b0;
      nx2_a_in = nx2_a_ff; pv2_a_in = pv2_a_ff;
      nx2_d_in = nx2_d_ff; pv2_d_in = pv2_d_ff;
      del_nb = NullIdx;
      if (cmd.rd2) begin
         // read outputs still hold the rd1 node's links (cursor or end node) from the first read
         if (op == OP_DEL_AFTER) nx_a = ad(nx_rd);
         else nx_a = ad(free_ff);
         pv_a = ad(pv_rd);
      end else if (cmd.out1) begin
         // flush deferred writes, read first value
         nx_we = nx2_v_ff; nx_a = nx2_a_ff; nx_wd = nx2_d_ff;
         pv_we = pv2_v_ff; pv_a = pv2_a_ff; pv_wd = pv2_d_ff;
         dt_a = ad(head_ff);
      end else if (cmd.out2) begin
         dt_a = ad(tail_ff);
      end else if (cmd.wr) begin
         unique case (op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE: begin
               if ((op == OP_INS_AFTER || op == OP_INS_BEFORE) && !c_ok) begin
               end else if (!alloc_ok) begin
                  err_in = 1'b1;
               end else begin
                  if (free_ff != NullIdx) free_in = f_link;
                  else fresh_in = fresh_ff + 9'd1;
                  count_in = count_ff + 9'd1;
                  dt_we = 1'b1; dt_a = ad(alloc);
                  nx_we = 1'b1; nx_a = ad(alloc);
                  pv_we = 1'b1; pv_a = ad(alloc);
                  unique case (op)
                     OP_INS_FIRST: begin
                        nx_wd = head_ff; pv_wd = NullIdx;
                        if (head_ff != NullIdx) begin
                           pv2_v_in = 1'b1; pv2_a_in = ad(head_ff); pv2_d_in = alloc;
                        end else tail_in = alloc;
                        head_in = alloc;
                     end
                     OP_INS_LAST: begin
                        pv_wd = tail_ff; nx_wd = NullIdx;
                        if (tail_ff != NullIdx) begin
                           nx2_v_in = 1'b1; nx2_a_in = ad(tail_ff); nx2_d_in = alloc;
                        end else head_in = alloc;
                        tail_in = alloc;
                     end
                     OP_INS_AFTER: begin
                        nx_wd = c_next_ff; pv_wd = cur_ff;
                        nx2_v_in = 1'b1; nx2_a_in = ad(cur_ff); nx2_d_in = alloc;
                        if (cur_ff == tail_ff) tail_in = alloc;
                        else begin
                           pv2_v_in = 1'b1; pv2_a_in = ad(c_next_ff); pv2_d_in = alloc;
                        end
                     end
                     default: begin
                        pv_wd = c_prev_ff; nx_wd = cur_ff;
                        pv2_v_in = 1'b1; pv2_a_in = ad(cur_ff); pv2_d_in = alloc;
                        if (cur_ff == head_ff) head_in = alloc;
                        else begin
                           nx2_v_in = 1'b1; nx2_a_in = ad(c_prev_ff); nx2_d_in = alloc;
                        end
                     end
                  endcase
               end
            end
            OP_CUR_FIRST: cur_in = head_ff;
            OP_CUR_LAST:  cur_in = tail_ff;
            OP_DEL_FIRST, OP_DEL_LAST: begin
               if (head_ff != NullIdx) begin
                  del_nb = rd1_node;
                  if (cur_ff == rd1_node) cur_in = NullIdx;
                  if (head_ff == tail_ff) begin
                     head_in = NullIdx; tail_in = NullIdx;
                  end else if (op == OP_DEL_FIRST) begin
                     head_in = c_next_ff;
                     pv_we = 1'b1; pv_a = ad(c_next_ff); pv_wd = NullIdx;
                  end else begin
                     tail_in = c_prev_ff;
                     nx2_v_in = 1'b1; nx2_a_in = ad(c_prev_ff); nx2_d_in = NullIdx;
                  end
               end
            end
            OP_DEL_AFTER: begin
               if (c_ok && c_next_ff != NullIdx) begin
                  del_nb = c_next_ff;
                  // e_link holds next of the victim
                  nx2_v_in = 1'b1; nx2_a_in = ad(cur_ff); nx2_d_in = e_link;
                  if (c_next_ff == tail_ff) tail_in = cur_ff;
                  else begin
                     pv_we = 1'b1; pv_a = ad(e_link); pv_wd = cur_ff;
                  end
               end
            end
            OP_DEL_BEFORE: begin
               if (c_ok && c_prev_ff != NullIdx) begin
                  del_nb = c_prev_ff;
                  // e_link holds prev of the victim
                  pv_we = 1'b1; pv_a = ad(cur_ff); pv_wd = e_link;
                  if (c_prev_ff == head_ff) head_in = cur_ff;
                  else begin
                     nx2_v_in = 1'b1; nx2_a_in = ad(e_link); nx2_d_in = cur_ff;
                  end
               end
            end
            OP_WRITE: if (c_ok) dt_we = 1'b1;
            OP_NEXT:  if (c_ok) cur_in = c_next_ff;
            OP_PREV:  if (c_ok) cur_in = c_prev_ff;
            OP_CLEAR: begin
               if (head_ff != NullIdx) begin
                  nx_we = 1'b1; nx_a = ad(tail_ff); nx_wd = free_ff;
                  free_in = head_ff;
               end
               head_in = NullIdx; tail_in = NullIdx; cur_in = NullIdx;
               count_in = '0;
            end
            default: ;
         endcase
         if (del_nb != NullIdx) begin
            // the victim's next link could go through the deferred next slot, but
            // del-after, del-before and del-last may take that slot, so push the
            // free link through the immediate next port instead.
            nx_we = 1'b1; nx_a = ad(del_nb); nx_wd = free_ff;
            free_in = del_nb;
            count_in = count_ff - 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NullIdx; tail_ff <= NullIdx; cur_ff <= NullIdx;
         free_ff <= NullIdx; fresh_ff <= '0; count_ff <= '0;
         nx2_v_ff <= 1'b0; pv2_v_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in;
            free_ff <= free_in; fresh_ff <= fresh_in; count_ff <= count_in;
            nx2_v_ff <= nx2_v_in; pv2_v_ff <= pv2_v_in;
         end else if (cmd.out1) begin
            nx2_v_ff <= 1'b0; pv2_v_ff <= 1'b0;
         end
      end
   end

   // The data port rests on the cursor node, so its value is ready in done.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff <= req_data.mode;
         val_ff  <= req_data.value;
      end
      if (cmd.wr) begin
         err_ff <= err_in;
         nx2_a_ff <= nx2_a_in; pv2_a_ff <= pv2_a_in;
         nx2_d_ff <= nx2_d_in; pv2_d_ff <= pv2_d_in;
      end
      if (cmd.out2) first_ff <= dt_rd;
      if (cmd.out3) last_ff <= dt_rd;
      if (cmd.done) begin
         rsp_ff.error         <= err_ff;
         rsp_ff.list_empty    <= (head_ff == NullIdx);
         rsp_ff.cursor_active <= c_ok;
         rsp_ff.first_value   <= (head_ff == NullIdx) ? '0 : first_ff;
         rsp_ff.last_value    <= (tail_ff == NullIdx) ? '0 : last_ff;
         rsp_ff.cursor_value  <= c_ok ? dt_rd : '0;
         rsp_ff.element_count <= count_ff;
      end
   end

   // Link capture: rd1 data arrives in rd2; rd2 data arrives in wr.
   always_ff @(posedge clock) begin
      if (cmd.rd2) begin
         c_next_ff <= nx_rd;
         c_prev_ff <= pv_rd;
      end
   end

   // e_link: far link of the victim for beside-cursor deletes; f_link: free
   // head's next. Both come from the rd2 read.
   always_comb begin
      e_link = (op == OP_DEL_AFTER) ? nx_rd : pv_rd;
      f_link = nx_rd;
   end

   assign rsp_data = rsp_ff;
endmodule

FILE: hw/rtl/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine.
`timescale 1ns / 1ps
// A doubly linked list of up to 256 signed 32-bit values with a cursor, held
// in three single-port node memories (next link, previous link, data) and a
// free list. Each request item applies one operation and returns one
// response item describing the list afterwards. An item passes through the
// read, update and value-readback steps on the single-port memories before
// its response; the engine accepts the next item only once it is back in
// idle after the response register is loaded, so items do not overlap. A
// stalled response holds the following item in its final step.
module doubly_linked_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dlle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dlle_pkg::rsp_type rsp_data
);
   import dlle_pkg::*;
   cmd_type cmd;

   dlle_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd);
   dlle_dpath u_dpath (
      .clock, .reset, .cmd, .req_data, .rsp_data);
endmodule
